// File: hw/rtl/oktv_pkg.sv
// oktv_pkg: shared types and defaults for the ordered key/value table
// operation codes, token control struct and default sizes
// no dependencies
package oktv_pkg;

    localparam int unsigned CAPACITY_DEF   = 256;
    localparam int unsigned KEY_BITS_DEF   = 32;
    localparam int unsigned VALUE_BITS_DEF = 32;
    localparam int unsigned POS_BITS       = 8;
    localparam int unsigned OP_BITS        = 3;

    typedef enum logic [OP_BITS-1:0] {
        OP_INSERT    = 3'd0,
        OP_UPDATE    = 3'd1,
        OP_INS_UPD   = 3'd2,
        OP_ERASE     = 3'd3,
        OP_LOOKUP    = 3'd4,
        OP_READ_IDX  = 3'd5
    } t_op;

    typedef struct packed {
        logic active;
        t_op  op;
        logic found;
        logic ok;
    } t_tok_ctl;

endpackage

// File: hw/rtl/ordered_key_value_table_unit.sv
// ordered_key_value_table_unit: top level of the ordered key/value table
// command token walks a chain of oktv_cell slots, result captured at the end
// depends on oktv_pkg and oktv_cell
//
// channel   dir  handshake              payload
// s (cmd)   in   i_s_tvalid/o_s_tready  tdata: key, value, position; tuser: operation
// m (rsp)   out  o_m_tvalid/i_m_tready  tdata: key, value, entry count; tuser: ok
//
// one command at a time: the token is registered at injection, steps one cell per cycle
// along the chain, and the result is registered at the end of the chain
// the next command is taken once the previous result transaction completes
// synchronous active-low reset empties the table (entry count zero)
// a stalled result holds; the command side waits while a result is pending
module ordered_key_value_table_unit #(
    parameter int unsigned CAPACITY   = oktv_pkg::CAPACITY_DEF,
    parameter int unsigned KEY_BITS   = oktv_pkg::KEY_BITS_DEF,
    parameter int unsigned VALUE_BITS = oktv_pkg::VALUE_BITS_DEF,
    parameter int unsigned CNT_W      = $clog2(CAPACITY + 1),
    parameter int unsigned IN_W  = ((KEY_BITS + VALUE_BITS + oktv_pkg::POS_BITS + 7) / 8) * 8,
    parameter int unsigned OUT_W = ((KEY_BITS + VALUE_BITS + CNT_W + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [IN_W-1:0]               i_s_tdata,  // lookup_key, new_value, position
    input  logic [oktv_pkg::OP_BITS-1:0]  i_s_tuser,  // operation
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [OUT_W-1:0]              o_m_tdata,  // key_out, value_out, entry_count
    output logic                          o_m_tuser   // ok
);
    import oktv_pkg::*;

    localparam int unsigned IN_USED  = KEY_BITS + VALUE_BITS + POS_BITS;

    t_tok_ctl              c_ctl  [0:CAPACITY];
    logic [KEY_BITS-1:0]   c_key  [0:CAPACITY];
    logic [VALUE_BITS-1:0] c_val  [0:CAPACITY];
    logic [POS_BITS-1:0]   c_pos  [0:CAPACITY];
    logic [KEY_BITS-1:0]   c_rkey [0:CAPACITY];
    logic [VALUE_BITS-1:0] c_rval [0:CAPACITY];
    logic [KEY_BITS-1:0]   s_key  [0:CAPACITY];
    logic [VALUE_BITS-1:0] s_val  [0:CAPACITY];

    t_tok_ctl              r_inj_ctl, n_inj_ctl;
    logic [KEY_BITS-1:0]   r_inj_key;
    logic [VALUE_BITS-1:0] r_inj_val;
    logic [POS_BITS-1:0]   r_inj_pos;

    logic                  r_busy, n_busy;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_ok;
    logic [KEY_BITS-1:0]   r_out_key;
    logic [VALUE_BITS-1:0] r_out_val;

    logic    s_accept;
    logic    m_accept;
    t_tok_ctl done;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign m_accept = r_out_valid && i_m_tready;
    assign done     = c_ctl[CAPACITY];

    assign c_ctl[0]  = r_inj_ctl;
    assign c_key[0]  = r_inj_key;
    assign c_val[0]  = r_inj_val;
    assign c_pos[0]  = r_inj_pos;
    assign c_rkey[0] = '0;
    assign c_rval[0] = '0;
    assign s_key[CAPACITY] = '0;
    assign s_val[CAPACITY] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        oktv_cell #(
            .CAPACITY   (CAPACITY),
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .CNT_W      (CNT_W),
            .IDX        (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_count    (r_count),
            .i_ctl      (c_ctl[g]),
            .i_key      (c_key[g]),
            .i_value    (c_val[g]),
            .i_pos      (c_pos[g]),
            .i_rkey     (c_rkey[g]),
            .i_rval     (c_rval[g]),
            .i_nb_key   (s_key[g+1]),
            .i_nb_val   (s_val[g+1]),
            .o_ctl      (c_ctl[g+1]),
            .o_key      (c_key[g+1]),
            .o_value    (c_val[g+1]),
            .o_pos      (c_pos[g+1]),
            .o_rkey     (c_rkey[g+1]),
            .o_rval     (c_rval[g+1]),
            .o_cell_key (s_key[g]),
            .o_cell_val (s_val[g])
        );
    end

    always_comb begin
        n_inj_ctl        = '0;
        n_inj_ctl.active = s_accept;
        n_inj_ctl.op     = t_op'(i_s_tuser);
        n_busy           = r_busy;
        n_count          = r_count;
        n_out_valid      = r_out_valid;
        if (s_accept) begin
            n_busy = 1'b1;
        end
        if (m_accept) begin
            n_out_valid = 1'b0;
            n_busy      = 1'b0;
        end
        if (done.active) begin
            n_out_valid = 1'b1;
            if (done.ok) begin
                case (done.op)
                    OP_INSERT: n_count = r_count + CNT_W'(1);
                    OP_INS_UPD: begin
                        if (!done.found) begin
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    OP_ERASE: n_count = r_count - CNT_W'(1);
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inj_ctl   <= '0;
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_inj_ctl   <= n_inj_ctl;
            r_busy      <= n_busy;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_inj_key <= i_s_tdata[KEY_BITS-1:0];
            r_inj_val <= i_s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
            r_inj_pos <= i_s_tdata[IN_USED-1:KEY_BITS+VALUE_BITS];
        end
        if (done.active) begin
            r_out_ok  <= done.ok;
            r_out_key <= c_rkey[CAPACITY];
            r_out_val <= c_rval[CAPACITY];
        end
    end

    assign o_s_tready = !r_busy;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_ok;
    assign o_m_tdata  = OUT_W'({r_count, r_out_val, r_out_key});

endmodule

// File: hw/rtl/oktv_cell.sv
// oktv_cell: one table slot plus one stage of the command token chain
// holds a key/value pair; matches, updates, inserts, reads out and shifts on erase
// depends on oktv_pkg
module oktv_cell #(
    parameter int unsigned CAPACITY   = oktv_pkg::CAPACITY_DEF,
    parameter int unsigned KEY_BITS   = oktv_pkg::KEY_BITS_DEF,
    parameter int unsigned VALUE_BITS = oktv_pkg::VALUE_BITS_DEF,
    parameter int unsigned CNT_W      = $clog2(CAPACITY + 1),
    parameter int unsigned IDX        = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [CNT_W-1:0]              i_count,
    input  oktv_pkg::t_tok_ctl            i_ctl,
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic [VALUE_BITS-1:0]         i_value,
    input  logic [oktv_pkg::POS_BITS-1:0] i_pos,
    input  logic [KEY_BITS-1:0]           i_rkey,
    input  logic [VALUE_BITS-1:0]         i_rval,
    input  logic [KEY_BITS-1:0]           i_nb_key,
    input  logic [VALUE_BITS-1:0]         i_nb_val,
    output oktv_pkg::t_tok_ctl            o_ctl,
    output logic [KEY_BITS-1:0]           o_key,
    output logic [VALUE_BITS-1:0]         o_value,
    output logic [oktv_pkg::POS_BITS-1:0] o_pos,
    output logic [KEY_BITS-1:0]           o_rkey,
    output logic [VALUE_BITS-1:0]         o_rval,
    output logic [KEY_BITS-1:0]           o_cell_key,
    output logic [VALUE_BITS-1:0]         o_cell_val
);
    import oktv_pkg::*;

    localparam bit HAS_NB = (IDX + 1 < CAPACITY);

    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_val, n_val;
    t_tok_ctl              r_ctl, n_ctl;
    logic [KEY_BITS-1:0]   r_tkey;
    logic [VALUE_BITS-1:0] r_tval;
    logic [POS_BITS-1:0]   r_pos;
    logic [KEY_BITS-1:0]   r_rkey, n_rkey;
    logic [VALUE_BITS-1:0] r_rval, n_rval;

    logic cell_valid;
    logic first_free;
    logic uses_key;
    logic hit;
    logic found_here;

    always_comb begin
        cell_valid = (32'(i_count) > IDX);
        first_free = (32'(i_count) == IDX);
        uses_key   = (i_ctl.op != OP_READ_IDX) && (i_ctl.op <= OP_LOOKUP);
        hit        = i_ctl.active && uses_key && cell_valid && !i_ctl.found
                     && (i_key == r_key);
        found_here = i_ctl.found || hit;

        n_key       = r_key;
        n_val       = r_val;
        n_ctl       = i_ctl;
        n_ctl.found = found_here;
        n_rkey      = i_rkey;
        n_rval      = i_rval;

        if (i_ctl.active) begin
            case (i_ctl.op)
                OP_INSERT, OP_INS_UPD: begin
                    if (hit && i_ctl.op == OP_INS_UPD) begin
                        n_val     = i_value;
                        n_ctl.ok  = 1'b1;
                    end else if (!found_here && first_free) begin
                        n_key     = i_key;
                        n_val     = i_value;
                        n_ctl.ok  = 1'b1;
                    end
                end
                OP_UPDATE: begin
                    if (hit) begin
                        n_val    = i_value;
                        n_ctl.ok = 1'b1;
                    end
                end
                OP_ERASE: begin
                    if (hit) begin
                        n_ctl.ok = 1'b1;
                    end
                    if (found_here && HAS_NB) begin
                        n_key = i_nb_key;
                        n_val = i_nb_val;
                    end
                end
                OP_LOOKUP: begin
                    if (hit) begin
                        n_rval   = r_val;
                        n_ctl.ok = 1'b1;
                    end
                end
                OP_READ_IDX: begin
                    if (cell_valid && (32'(i_pos) == IDX)) begin
                        n_rkey   = r_key;
                        n_rval   = r_val;
                        n_ctl.ok = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_val  <= n_val;
        r_tkey <= i_key;
        r_tval <= i_value;
        r_pos  <= i_pos;
        r_rkey <= n_rkey;
        r_rval <= n_rval;
    end

    assign o_ctl      = r_ctl;
    assign o_key      = r_tkey;
    assign o_value    = r_tval;
    assign o_pos      = r_pos;
    assign o_rkey     = r_rkey;
    assign o_rval     = r_rval;
    assign o_cell_key = r_key;
    assign o_cell_val = r_val;

endmodule

// File: sim/tb_ordered_key_value_table_unit.sv
// tb_ordered_key_value_table_unit: self-checking testbench for the ordered key/value table
// drives command transactions, predicts every response and compares field by field
// depends on oktv_pkg and ordered_key_value_table_unit
module tb_ordered_key_value_table_unit;

    import oktv_pkg::*;

    localparam int unsigned CAPACITY       = CAPACITY_DEF;
    localparam int unsigned CNT_W          = $clog2(CAPACITY + 1);
    localparam int unsigned IN_W           = ((KEY_BITS_DEF + VALUE_BITS_DEF + POS_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_W          = ((KEY_BITS_DEF + VALUE_BITS_DEF + CNT_W + 7) / 8) * 8;
    localparam int          WATCHDOG_LIMIT = 8 * (CAPACITY + 2 + 20);
    localparam int          KEY_POOL_SIZE  = 320;
    localparam int          RANDOM_ITEMS   = 900;

    // operation codes the package leaves unnamed
    localparam logic [OP_BITS-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_BITS-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        bit        ok;
        bit [31:0] key;
        bit [31:0] value;
        bit [8:0]  count;
    } t_table_rsp;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [IN_W-1:0]    i_s_tdata;   // lookup_key, new_value, position
    logic [OP_BITS-1:0] i_s_tuser;   // operation
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [OUT_W-1:0]   o_m_tdata;   // key_out, value_out, entry_count
    logic               o_m_tuser;   // ok

    bit [31:0]  tbl_key [CAPACITY];
    bit [31:0]  tbl_val [CAPACITY];
    int         tbl_fill;
    bit [31:0]  key_pool [KEY_POOL_SIZE];
    t_table_rsp expected_rsp_q [$];
    t_table_rsp expected_head;
    int         mismatch_count;
    int         idle_cycles;
    int         rsp_stall;
    bit         no_idle;

    ordered_key_value_table_unit #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS_DEF),
        .VALUE_BITS (VALUE_BITS_DEF)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic int find_slot(bit [31:0] key);
        int i;
        for (i = 0; i < tbl_fill; i++) begin
            if (tbl_key[i] == key) return i;
        end
        return tbl_fill;
    endfunction

    function automatic bit try_insert(bit [31:0] key, bit [31:0] value);
        if (tbl_fill >= CAPACITY || find_slot(key) < tbl_fill) return 1'b0;
        tbl_key[tbl_fill] = key;
        tbl_val[tbl_fill] = value;
        tbl_fill++;
        return 1'b1;
    endfunction

    function automatic bit try_update(bit [31:0] key, bit [31:0] value);
        int slot;
        slot = find_slot(key);
        if (slot >= tbl_fill) return 1'b0;
        tbl_val[slot] = value;
        return 1'b1;
    endfunction

    function automatic t_table_rsp predict_table_rsp(logic [OP_BITS-1:0] op, bit [31:0] key,
                                                     bit [31:0] value, bit [7:0] pos);
        t_table_rsp rsp;
        int         slot;
        int         i;
        rsp  = '0;
        slot = find_slot(key);
        case (op)
            OP_INSERT:   rsp.ok = try_insert(key, value);
            OP_UPDATE:   rsp.ok = try_update(key, value);
            OP_INS_UPD:  rsp.ok = try_update(key, value) || try_insert(key, value);
            OP_ERASE: begin
                if (slot < tbl_fill) begin
                    for (i = slot; i + 1 < tbl_fill; i++) begin
                        tbl_key[i] = tbl_key[i + 1];
                        tbl_val[i] = tbl_val[i + 1];
                    end
                    tbl_fill--;
                    rsp.ok = 1'b1;
                end
            end
            OP_LOOKUP: begin
                if (slot < tbl_fill) begin
                    rsp.value = tbl_val[slot];
                    rsp.ok    = 1'b1;
                end
            end
            OP_READ_IDX: begin
                if (pos < tbl_fill) begin
                    rsp.key   = tbl_key[pos];
                    rsp.value = tbl_val[pos];
                    rsp.ok    = 1'b1;
                end
            end
            default: ;
        endcase
        rsp.count = 9'(tbl_fill);
        return rsp;
    endfunction

    task automatic send_command(input logic [OP_BITS-1:0] op, input bit [31:0] key,
                                input bit [31:0] value, input bit [7:0] pos);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        // sometimes hold off until the table is idle so the gap lands after ready
        if (!no_idle && $urandom_range(0, 3) == 0 && expected_rsp_q.size() != 0) begin
            i_s_tvalid = 1'b0;
            while (expected_rsp_q.size() != 0) @(negedge i_clk);
        end
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = IN_W'({pos, value, key});
        i_s_tuser  = op;
        do @(posedge i_clk); while (!o_s_tready);
        expected_rsp_q.push_back(predict_table_rsp(op, key, value, pos));
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [OP_BITS-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 18) return OP_INSERT;
        if (r < 30) return OP_UPDATE;
        if (r < 48) return OP_INS_UPD;
        if (r < 66) return OP_ERASE;
        if (r < 82) return OP_LOOKUP;
        if (r < 98) return OP_READ_IDX;
        if (r < 99) return OP_SPARE_6;
        return OP_SPARE_7;
    endfunction

    function automatic bit [31:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom;
        if (r < 5 && tbl_fill > 0) return tbl_key[$urandom_range(0, tbl_fill - 1)];
        return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    endfunction

    function automatic bit [7:0] pick_pos();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, (tbl_fill > 255) ? 255 : tbl_fill));
    endfunction

    task automatic test_directed();
        send_command(OP_LOOKUP,   32'h0000_0000, 32'h0000_0000, 8'd0);
        send_command(OP_READ_IDX, 32'h0000_0000, 32'h0000_0000, 8'd0);
        send_command(OP_ERASE,    32'h0000_0005, 32'h0000_0000, 8'd0);
        send_command(OP_UPDATE,   32'h0000_0005, 32'h1111_1111, 8'd0);
        send_command(OP_INSERT,   32'h0000_0000, 32'h0000_0000, 8'd0);
        send_command(OP_INSERT,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_command(OP_INSERT,   32'h0000_0000, 32'h0000_1234, 8'd0);
        send_command(OP_INS_UPD,  32'h0000_1234, 32'hA5A5_A5A5, 8'd0);
        send_command(OP_INS_UPD,  32'hFFFF_FFFF, 32'h5A5A_5A5A, 8'd0);
        send_command(OP_UPDATE,   32'h0000_0000, 32'hFFFF_FFFF, 8'd0);
        send_command(OP_LOOKUP,   32'h0000_0000, 32'h0000_0000, 8'd0);
        send_command(OP_LOOKUP,   32'hFFFF_FFFF, 32'h0000_0000, 8'd0);
        send_command(OP_LOOKUP,   32'h0000_0077, 32'h0000_0000, 8'd0);
        send_command(OP_READ_IDX, 32'h0000_0000, 32'h0000_0000, 8'd0);
        send_command(OP_READ_IDX, 32'h0000_0000, 32'h0000_0000, 8'd2);
        send_command(OP_READ_IDX, 32'h0000_0000, 32'h0000_0000, 8'd3);
        send_command(OP_READ_IDX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
        send_command(OP_SPARE_6,  32'h0000_1234, 32'hFFFF_FFFF, 8'd1);
        send_command(OP_SPARE_7,  32'hFFFF_FFFF, 32'h0000_0001, 8'd0);
        send_command(OP_ERASE,    32'hFFFF_FFFF, 32'h0000_0000, 8'd0);
        send_command(OP_READ_IDX, 32'h0000_0000, 32'h0000_0000, 8'd1);
        send_command(OP_ERASE,    32'h0000_1234, 32'h0000_0000, 8'd0);
        send_command(OP_READ_IDX, 32'h0000_0000, 32'h0000_0000, 8'd1);
        send_command(OP_ERASE,    32'h0000_0000, 32'h0000_0000, 8'd0);
        send_command(OP_LOOKUP,   32'h0000_0000, 32'h0000_0000, 8'd0);
    endtask

    task automatic test_fill_to_capacity();
        int idx;
        idx     = 0;
        no_idle = 1'b1;
        while (tbl_fill < CAPACITY && idx < KEY_POOL_SIZE - 4) begin
            send_command(idx[0] ? OP_INSERT : OP_INS_UPD, key_pool[idx], $urandom,
                         8'($urandom));
            if (idx % 8 == 7) send_command(OP_LOOKUP, pick_key(), $urandom, 8'($urandom));
            idx++;
        end
        no_idle = 1'b0;
        // table full at this point
        send_command(OP_INSERT,   key_pool[idx],     $urandom, 8'($urandom));
        send_command(OP_INS_UPD,  key_pool[idx + 1], $urandom, 8'($urandom));
        send_command(OP_INS_UPD,  tbl_key[CAPACITY / 2], $urandom, 8'($urandom));
        send_command(OP_READ_IDX, $urandom, $urandom, 8'd255);
        send_command(OP_READ_IDX, $urandom, $urandom, 8'd0);
        send_command(OP_ERASE,    tbl_key[tbl_fill - 1], $urandom, 8'($urandom));
        send_command(OP_READ_IDX, $urandom, $urandom, 8'd255);
        send_command(OP_INSERT,   key_pool[idx + 2], $urandom, 8'($urandom));
    endtask

    task automatic test_random_mix();
        int n;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= 400 && n < 500);
            send_command(pick_op(), pick_key(), $urandom, pick_pos());
        end
        no_idle = 1'b0;
    endtask

    task automatic test_drain_table();
        int r;
        while (tbl_fill > 0) begin
            r = $urandom_range(0, 9);
            if (r < 6)
                send_command(OP_ERASE, tbl_key[$urandom_range(0, tbl_fill - 1)], $urandom,
                             8'($urandom));
            else if (r < 7)
                send_command(OP_ERASE, tbl_key[tbl_fill - 1], $urandom, 8'($urandom));
            else if (r < 8)
                send_command(OP_ERASE, $urandom, $urandom, 8'($urandom));
            else
                send_command(OP_READ_IDX, $urandom, $urandom, pick_pos());
        end
        send_command(OP_LOOKUP,   pick_key(), $urandom, 8'($urandom));
        send_command(OP_READ_IDX, $urandom, $urandom, 8'd0);
    endtask

    task automatic check_field(input string name, input bit [31:0] want, input bit [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // response checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            rsp_stall = no_idle ? 0 : $urandom_range(0, 9);
            if (expected_rsp_q.size() == 0) begin
                $display("%0t: unexpected response transaction, expected none actual %h",
                         $time, o_m_tdata);
                mismatch_count++;
            end else begin
                expected_head = expected_rsp_q.pop_front();
                check_field("ok",          32'(expected_head.ok), 32'(o_m_tuser));
                check_field("key_out",     expected_head.key,     o_m_tdata[31:0]);
                check_field("value_out",   expected_head.value,   o_m_tdata[63:32]);
                check_field("entry_count", 32'(expected_head.count),
                            32'(o_m_tdata[64 +: CNT_W]));
            end
        end
    end

    // response side stall, counted only while a response is offered
    always @(negedge i_clk) begin
        if (rsp_stall > 0) begin
            i_m_tready = 1'b0;
            if (o_m_tvalid) rsp_stall--;
        end else begin
            i_m_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d responses outstanding",
                         $time, expected_rsp_q.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        int i;
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = '0;
        i_m_tready     = 1'b0;
        tbl_fill       = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        rsp_stall      = 0;
        no_idle        = 1'b0;
        for (i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        wait_for_results();
        test_fill_to_capacity();
        wait_for_results();
        test_random_mix();
        wait_for_results();
        test_drain_table();
        wait_for_results();

        repeat (CAPACITY + 8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/oktv_pkg.sv
hw/rtl/oktv_cell.sv
hw/rtl/ordered_key_value_table_unit.sv
sim/tb_ordered_key_value_table_unit.sv
